### hw/rtl/assert_macros.svh
// assertion macros used by the resampler rtl
// expects clk and rst to be in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/pucr_pkg.sv
// constants and types of the polyline chord resampler
// no dependencies
package pucr_pkg;

  localparam int COORD_W     = 31;
  localparam int CHORD_W     = 62;
  localparam int DATA_W      = 64;
  localparam int MAX_SAMPLES = 64;
  localparam int CNT_W       = 7;
  localparam int FRAC        = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MAG_W       = 2 * DIFF_W;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int DISC_W      = PROD_W + 1;
  localparam int ROOT_W      = 88;
  localparam int SREM_W      = ROOT_W + 2;
  localparam int QUO_W       = 90;
  localparam int NUM_W       = QUO_W + 1;
  localparam int T_W         = FRAC + 1;
  localparam int ALONG_W     = T_W + DIFF_W;
  localparam int STEP_W      = 7;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_EMIT  = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_DIVLD = 8'b0100_0000,
    S_DIV   = 8'b1000_0000
  } state_t;

  typedef enum logic [3:0] {
    OP_EX2, OP_EY2, OP_DX2, OP_DY2, OP_FXDX, OP_FYDY,
    OP_FX2, OP_FY2, OP_HH, OP_AC, OP_TX, OP_TY
  } op_t;

endpackage

### hw/rtl/polyline_uniform_chord_resampler.sv
// polyline chord resampler: a line start vertex goes from S_IDLE to S_EMIT and then to
// the output register; each sample of a later vertex is found by the shift-add multiplier
// (one bit a cycle, twelve products), the 88-step root and up to two 90-step divides
// accepts one vertex at a time; a vertex within reach emits no sample
// rst is synchronous: clears control and line state, chord register back to 10^12
// depends on pucr_pkg and assert_macros.svh
`include "assert_macros.svh"

module polyline_uniform_chord_resampler import pucr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // vertex_x [30:0], vertex_y [61:31], zero
  input  logic              s_axis_tuser,  // starts_line
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // sample_x [30:0], sample_y [61:31], zero
  output logic              m_axis_tlast,  // last_of_run
  output logic              m_axis_tuser,  // run_truncated
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CHORD_W-1:0] cfg_data
);

  localparam logic [T_W-1:0]     ONE  = T_W'(1) << FRAC;
  localparam logic [ALONG_W-1:0] HALF = ALONG_W'(1) << (FRAC - 1);

  state_t state;
  op_t    op;

  logic [CHORD_W-1:0] r2;
  logic [COORD_W-1:0] lx, ly, px, py, vx, vy, sx, sy, nx;
  logic               line_open;
  logic [CNT_W-1:0]   n_cnt;
  logic               far, pend_last, pend_trunc;

  logic [PROD_W-1:0]  mcand, acc;
  logic [MAG_W-1:0]   mplier;
  logic [MAG_W-1:0]   d2, a_sum;
  logic [MAG_W:0]     h_val, c_val;
  logic [DISC_W-1:0]  disc;
  logic [ROOT_W-1:0]  root;
  logic [SREM_W-1:0]  srem;
  logic [ROOT_W:0]    s_val;
  logic [QUO_W-1:0]   dq;
  logic [MAG_W-1:0]   drem;
  logic               dneg, t_sel;
  logic [T_W-1:0]     t_val;
  logic [STEP_W-1:0]  step;

  logic               o_valid, o_last, o_trunc;
  logic [COORD_W-1:0] ox, oy;

  function automatic logic [DIFF_W-1:0] diff(input logic [COORD_W-1:0] p,
                                             input logic [COORD_W-1:0] q);
    diff = {p[COORD_W-1], p} - {q[COORD_W-1], q};
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
  endfunction

  logic [DIFF_W-1:0] ex, ey, dx, dy, fx, fy;
  logic [MAG_W:0]    h_neg, c_neg;
  logic [MAG_W-1:0]  h_mag, c_mag, opa, opb, prod_lo;

  assign ex = diff(lx, vx);
  assign ey = diff(ly, vy);
  assign dx = diff(vx, sx);
  assign dy = diff(vy, sy);
  assign fx = diff(sx, lx);
  assign fy = diff(sy, ly);
  assign h_neg = ~h_val + (MAG_W+1)'(1);
  assign c_neg = ~c_val + (MAG_W+1)'(1);
  assign h_mag = h_val[MAG_W] ? h_neg[MAG_W-1:0] : h_val[MAG_W-1:0];
  assign c_mag = c_val[MAG_W] ? c_neg[MAG_W-1:0] : c_val[MAG_W-1:0];
  assign prod_lo = acc[MAG_W-1:0];

  // operand pairs of each product
  always_comb begin
    case (op)
      OP_EX2:  begin opa = MAG_W'(mag(ex)); opb = MAG_W'(mag(ex)); end
      OP_EY2:  begin opa = MAG_W'(mag(ey)); opb = MAG_W'(mag(ey)); end
      OP_DX2:  begin opa = MAG_W'(mag(dx)); opb = MAG_W'(mag(dx)); end
      OP_DY2:  begin opa = MAG_W'(mag(dy)); opb = MAG_W'(mag(dy)); end
      OP_FXDX: begin opa = MAG_W'(mag(dx)); opb = MAG_W'(mag(fx)); end
      OP_FYDY: begin opa = MAG_W'(mag(dy)); opb = MAG_W'(mag(fy)); end
      OP_FX2:  begin opa = MAG_W'(mag(fx)); opb = MAG_W'(mag(fx)); end
      OP_FY2:  begin opa = MAG_W'(mag(fy)); opb = MAG_W'(mag(fy)); end
      OP_HH:   begin opa = h_mag; opb = h_mag; end
      OP_AC:   begin opa = a_sum; opb = c_mag; end
      OP_TX:   begin opa = MAG_W'(mag(dx)); opb = MAG_W'(t_val); end
      OP_TY:   begin opa = MAG_W'(mag(dy)); opb = MAG_W'(t_val); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // write-back arithmetic
  logic [MAG_W-1:0]   d2_sum;
  logic               far_w, term_neg;
  logic [MAG_W:0]     term, c_next;
  logic [DISC_W-1:0]  disc_ac;
  logic [ALONG_W-1:0] rnd;
  logic [DIFF_W:0]    m_ext, base_ext, along_w;
  logic               along_neg;

  assign d2_sum   = d2 + prod_lo;
  assign far_w    = d2_sum > MAG_W'(r2);
  assign term_neg = (op == OP_FXDX) ? (fx[DIFF_W-1] ^ dx[DIFF_W-1])
                                    : (fy[DIFF_W-1] ^ dy[DIFF_W-1]);
  assign term     = term_neg ? (~{1'b0, prod_lo} + (MAG_W+1)'(1)) : {1'b0, prod_lo};
  assign c_next   = c_val + {1'b0, prod_lo} - (MAG_W+1)'(r2);
  assign disc_ac  = c_val[MAG_W] ? (disc + {1'b0, acc}) : (disc - {1'b0, acc});
  assign rnd      = acc[ALONG_W-1:0] + HALF;
  assign m_ext    = (DIFF_W+1)'(rnd[ALONG_W-1:FRAC]);
  assign along_neg = (op == OP_TY) ? dy[DIFF_W-1] : dx[DIFF_W-1];
  assign base_ext = (op == OP_TY) ? {{2{sy[COORD_W-1]}}, sy} : {{2{sx[COORD_W-1]}}, sx};
  assign along_w  = along_neg ? (base_ext - m_ext) : (base_ext + m_ext);

  // root and divide steps
  logic [SREM_W+1:0] rem_sh, trial;
  logic              sq_ge, dge, rnd_up, t_ok;
  logic [MAG_W:0]    rem2;
  logic [NUM_W-1:0]  hs, s_ext, num, num_neg;
  logic [QUO_W:0]    q_r;

  assign rem_sh = {srem, disc[PROD_W-1:PROD_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign rem2   = {drem, dq[QUO_W-1]};
  assign dge    = rem2 >= {1'b0, a_sum};
  assign rnd_up = {drem, 1'b0} >= {1'b0, a_sum};
  assign q_r    = {1'b0, dq} + (QUO_W+1)'(rnd_up);
  assign t_ok   = (q_r == '0) || (!dneg && (q_r <= (QUO_W+1)'(ONE)));
  assign hs     = {{(NUM_W-MAG_W-1-FRAC){h_val[MAG_W]}}, h_val, {FRAC{1'b0}}};
  assign s_ext  = NUM_W'(s_val);
  assign num    = t_sel ? (s_ext - hs) : (~hs + NUM_W'(1) - s_ext);
  assign num_neg = ~num + NUM_W'(1);

  logic emit_ok, emit_fire;
  assign emit_ok   = !o_valid || m_axis_tready;
  assign emit_fire = (state == S_EMIT) && emit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_EX2;
      r2        <= CHORD_W'(64'd1000000000000);
      line_open <= 1'b0;
      lx        <= '0;
      ly        <= '0;
      px        <= '0;
      py        <= '0;
      n_cnt     <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (cfg_valid) r2 <= cfg_data;
      if (emit_fire) o_valid <= 1'b1;
      else if (m_axis_tready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            vx <= s_axis_tdata[COORD_W-1:0];
            vy <= s_axis_tdata[2*COORD_W-1:COORD_W];
            if (s_axis_tuser || !line_open) begin
              lx         <= s_axis_tdata[COORD_W-1:0];
              ly         <= s_axis_tdata[2*COORD_W-1:COORD_W];
              line_open  <= 1'b1;
              pend_last  <= 1'b1;
              pend_trunc <= 1'b0;
              state      <= S_EMIT;
            end else begin
              n_cnt <= '0;
              op    <= OP_EX2;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          mcand  <= PROD_W'(opa);
          mplier <= opb;
          acc    <= '0;
          state  <= S_MUL;
        end
        S_MUL: begin
          if (mplier != '0) begin
            if (mplier[0]) acc <= acc + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            case (op)
              OP_EX2: begin d2 <= prod_lo; op <= OP_EY2; state <= S_LOAD; end
              OP_EY2: begin far <= far_w; state <= S_CHECK; end
              OP_DX2: begin a_sum <= prod_lo; op <= OP_DY2; state <= S_LOAD; end
              OP_DY2: begin a_sum <= a_sum + prod_lo; op <= OP_FXDX; state <= S_LOAD; end
              OP_FXDX: begin h_val <= term; op <= OP_FYDY; state <= S_LOAD; end
              OP_FYDY: begin h_val <= h_val + term; op <= OP_FX2; state <= S_LOAD; end
              OP_FX2: begin c_val <= {1'b0, prod_lo}; op <= OP_FY2; state <= S_LOAD; end
              OP_FY2: begin
                c_val <= c_next;
                if (a_sum == '0) begin
                  // degenerate segment: origin
                  lx <= '0; ly <= '0; n_cnt <= n_cnt + CNT_W'(1);
                  op <= OP_EX2;
                end else begin
                  op <= OP_HH;
                end
                state <= S_LOAD;
              end
              OP_HH: begin disc <= {1'b0, acc}; op <= OP_AC; state <= S_LOAD; end
              OP_AC: begin
                if (disc_ac[DISC_W-1]) begin
                  lx <= '0; ly <= '0; n_cnt <= n_cnt + CNT_W'(1);
                  op <= OP_EX2; state <= S_LOAD;
                end else begin
                  disc  <= disc_ac;
                  root  <= '0;
                  srem  <= '0;
                  step  <= STEP_W'(ROOT_W);
                  state <= S_SQRT;
                end
              end
              OP_TX: begin nx <= along_w[COORD_W-1:0]; op <= OP_TY; state <= S_LOAD; end
              OP_TY: begin
                lx    <= nx;
                ly    <= along_w[COORD_W-1:0];
                n_cnt <= n_cnt + CNT_W'(1);
                op    <= OP_EX2;
                state <= S_LOAD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CHECK: begin
          if (n_cnt == '0) begin
            if (far) begin
              sx <= px; sy <= py; op <= OP_DX2; state <= S_LOAD;
            end else begin
              px <= vx; py <= vy; state <= S_IDLE;
            end
          end else begin
            pend_last  <= !far || (n_cnt == CNT_W'(MAX_SAMPLES));
            pend_trunc <= far && (n_cnt == CNT_W'(MAX_SAMPLES));
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            ox      <= lx;
            oy      <= ly;
            o_last  <= pend_last;
            o_trunc <= pend_trunc;
            if (pend_last) begin
              px <= vx; py <= vy; state <= S_IDLE;
            end else begin
              // later crossings start from the last sample
              sx <= lx; sy <= ly; op <= OP_DX2; state <= S_LOAD;
            end
          end
        end
        S_SQRT: begin
          if (step != '0) begin
            disc <= {disc[DISC_W-1], disc[PROD_W-3:0], 2'b00};
            srem <= sq_ge ? SREM_W'(rem_sh - trial) : rem_sh[SREM_W-1:0];
            root <= {root[ROOT_W-2:0], sq_ge};
            step <= step - STEP_W'(1);
          end else begin
            s_val <= {1'b0, root} + (ROOT_W+1)'(srem > SREM_W'(root));
            t_sel <= 1'b0;
            state <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          dneg  <= num[NUM_W-1];
          dq    <= num[NUM_W-1] ? num_neg[QUO_W-1:0] : num[QUO_W-1:0];
          drem  <= '0;
          step  <= STEP_W'(QUO_W);
          state <= S_DIV;
        end
        S_DIV: begin
          if (step != '0) begin
            drem <= dge ? MAG_W'(rem2 - {1'b0, a_sum}) : rem2[MAG_W-1:0];
            dq   <= {dq[QUO_W-2:0], dge};
            step <= step - STEP_W'(1);
          end else if (t_ok) begin
            t_val <= q_r[T_W-1:0];
            op    <= OP_TX;
            state <= S_LOAD;
          end else if (!t_sel) begin
            t_sel <= 1'b1;
            state <= S_DIVLD;
          end else begin
            // neither root on the segment: origin
            lx <= '0; ly <= '0; n_cnt <= n_cnt + CNT_W'(1);
            op <= OP_EX2; state <= S_LOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {{(DATA_W-2*COORD_W){1'b0}}, oy, ox};
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_trunc;

  `ASSERT_IMPLIES(a_cnt_cap, 1'b1, n_cnt <= CNT_W'(MAX_SAMPLES))
  `ASSERT_IMPLIES(a_t_range, (state == S_LOAD) && (op == OP_TX), t_val <= ONE)
  `ASSERT_IMPLIES(a_disc_pos, state == S_SQRT, !disc[DISC_W-1])
  `ASSERT_IMPLIES(a_trunc_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `ASSERT_NEXT(a_start_emit, s_axis_tvalid && s_axis_tready && s_axis_tuser,
               state == S_EMIT)

endmodule
